FILE: rtl/core/floor_ceiling_texel_fog_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the floor and ceiling texel block
// Each macro expands to one labelled concurrent assertion on a clock.
// ----------------------------------------------------------------------------
`ifndef FLOOR_CEILING_TEXEL_FOG_ASSERT_SVH
`define FLOOR_CEILING_TEXEL_FOG_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define FCTF_ASSERT_NOW(label, clk, rst, pre, post, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
      else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define FCTF_ASSERT_NEXT(label, clk, rst, pre, post, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
      else $error(msg);

`endif

FILE: rtl/core/fctf_pkg.sv
// ----------------------------------------------------------------------------
// fctf_pkg
// Types and constants shared by the floor and ceiling texel block.
// ----------------------------------------------------------------------------
package fctf_pkg;

   // Input item as seen on the request queue.
   typedef struct packed {
      logic               action;
      logic               is_floor;
      logic [10:0]        screen_y;
      logic signed [19:0] rel_height;
      logic signed [15:0] ray_dir_x;
      logic signed [15:0] ray_dir_y;
      logic [10:0]        tex_width;
      logic [10:0]        tex_height;
      logic [23:0]        texel_color;
      logic [8:0]         fog_in;
   } req_type;

   // Result item as seen on the response queue.
   typedef struct packed {
      logic        skipped;
      logic [9:0]  tex_x;
      logic [9:0]  tex_y;
      logic [8:0]  fog_factor;
      logic [23:0] shaded_color;
   } rsp_type;

   // Configuration registers.
   typedef struct packed {
      logic signed [15:0] horizon_row;
      logic [10:0]        half_screen_h;
      logic signed [23:0] cam_x;
      logic signed [23:0] cam_y;
      logic [15:0]        tex_scale;
   } cfg_type;

   // Register indexes on the configuration port.
   localparam logic [2:0] RegHorizonRow = 3'd0;
   localparam logic [2:0] RegHalfScreen = 3'd1;
   localparam logic [2:0] RegCamX       = 3'd2;
   localparam logic [2:0] RegCamY       = 3'd3;
   localparam logic [2:0] RegTexScale   = 3'd4;

   // Reset values of the registers.
   localparam logic [10:0] HalfScreenReset = 11'd240;
   localparam logic [15:0] TexScaleReset   = 16'd256;

   // Action codes.
   localparam logic ActLocate = 1'b0;
   localparam logic ActShade  = 1'b1;

   // Distance limits in Q16.16 (0.1 and 1000).
   localparam logic [25:0] DistMin = 26'd6554;
   localparam logic [25:0] DistMax = 26'd65536000;

   // Fog: drop = floor(D / 76800), at most 192. Distances above the last
   // step are clipped first, then a reciprocal multiply gives the exact floor.
   localparam logic [23:0] FogClampD = 24'd14822399;
   localparam logic [23:0] FogRecip  = 24'd14316558;
   localparam logic [8:0]  FogFull   = 9'd256;
   localparam logic [8:0]  FogMin    = 9'd64;

   // Horizon test scale.
   localparam logic [26:0] SkipScale = 27'd1000;

   // Back pipeline layout.
   localparam int unsigned DivSteps = 26;
   localparam int unsigned ModSteps = 25;
   localparam int unsigned StClamp  = DivSteps;
   localparam int unsigned StMul    = StClamp + 1;
   localparam int unsigned StSum    = StMul + 1;
   localparam int unsigned StPart   = StSum + 1;
   localparam int unsigned StAdd    = StPart + 1;
   localparam int unsigned StAbs    = StAdd + 1;
   localparam int unsigned StMod0   = StAbs + 1;
   localparam int unsigned PipeLen  = StMod0 + ModSteps;

   // Classified item handed from the front to the back.
   typedef struct packed {
      logic               action;
      logic               skip;
      logic               sat;
      logic [16:0]        ad;
      logic [30:0]        num;
      logic signed [15:0] ray_x;
      logic signed [15:0] ray_y;
      logic [10:0]        tw;
      logic [10:0]        th;
      logic [8:0]         fog;
      logic [23:0]        color;
   } front_type;

   // Working state of one item in the back pipeline.
   typedef struct packed {
      front_type          f;
      logic [16:0]        rem;
      logic [25:0]        xbits;
      logic [25:0]        quo;
      logic [25:0]        row_dist;
      logic [23:0]        dfog;
      logic signed [42:0] px;
      logic signed [42:0] py;
      logic [47:0]        fprod;
      logic signed [46:0] wx;
      logic signed [46:0] wy;
      logic signed [39:0] hx;
      logic signed [39:0] hy;
      logic [39:0]        lx;
      logic [39:0]        ly;
      logic signed [63:0] sx;
      logic signed [63:0] sy;
      logic               negx;
      logic               negy;
      logic [24:0]        magx;
      logic [24:0]        magy;
      logic [10:0]        remx;
      logic [10:0]        remy;
   } work_type;

endpackage

FILE: rtl/core/fctf_fifo.sv
// ----------------------------------------------------------------------------
// fctf_fifo
// Small register queue with push/full and pop/empty handshakes.
// ----------------------------------------------------------------------------
module fctf_fifo #(
   parameter type         item_type = logic,
   parameter int unsigned DEPTH     = 4
) (
   input  logic     clock,
   input  logic     reset,
   input  logic     push,
   input  item_type wdata,
   output logic     full,
   input  logic     pop,
   output item_type rdata,
   output logic     empty
);

   localparam int unsigned PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int unsigned CntW = $clog2(DEPTH + 1);

   item_type          mem_ff [DEPTH];
   logic [PtrW-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PtrW-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CntW-1:0]   count_ff, count_in;
   logic              do_push, do_pop;

   assign full    = (count_ff == CntW'(DEPTH));
   assign empty   = (count_ff == '0);
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;
   assign rdata   = mem_ff[rd_ptr_ff];

   // Pointer and count update.
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PtrW'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PtrW'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Storage holds payload only.
   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= wdata;
      end
   end

endmodule

FILE: rtl/core/fctf_front.sv
// ----------------------------------------------------------------------------
// fctf_front
// Classifies an incoming item: horizon test, row offset, distance numerator,
// texture size limits, and the whole of the shade action.
// ----------------------------------------------------------------------------
module fctf_front
   import fctf_pkg::*;
#(
   parameter int unsigned MAX_TEX_SIZE    = 1024,
   parameter int unsigned MAX_SCREEN_ROWS = 2048
) (
   input  req_type   req_item,
   input  cfg_type   cfg,
   output front_type item
);

   localparam int unsigned RowCapInt  =
      (MAX_SCREEN_ROWS - 1 < 2047) ? MAX_SCREEN_ROWS - 1 : 2047;
   localparam int unsigned SizeCapInt = (MAX_TEX_SIZE < 2047) ? MAX_TEX_SIZE : 2047;
   localparam logic [10:0] RowCap     = 11'(RowCapInt);
   localparam logic [10:0] SizeCap    = 11'(SizeCapInt);

   logic [10:0]        row;
   logic [10:0]        half;
   logic signed [17:0] diff;
   logic [16:0]        ad;
   logic [19:0]        arel;
   logic [30:0]        num;
   logic [8:0]         fog;
   logic [7:0]         red, green, blue;

   // Row offset from the horizon and the horizon test.
   always_comb begin
      row  = (req_item.screen_y > RowCap) ? RowCap : req_item.screen_y;
      half = (cfg.half_screen_h == '0) ? 11'd1 : cfg.half_screen_h;
      diff = 18'(cfg.horizon_row) - $signed({3'b000, row, 4'b0000});
      ad   = diff[17] ? 17'(-diff) : 17'(diff);
      arel = req_item.rel_height[19] ? 20'(-req_item.rel_height)
                                     : 20'(req_item.rel_height);
      num  = 31'(arel) * 31'(half);
   end

   // Shade: clip the fog factor and scale each channel.
   always_comb begin
      if (req_item.fog_in < FogMin) begin
         fog = FogMin;
      end else if (req_item.fog_in > FogFull) begin
         fog = FogFull;
      end else begin
         fog = req_item.fog_in;
      end
      red   = 8'((17'(req_item.texel_color[23:16]) * 17'(fog)) >> 8);
      green = 8'((17'(req_item.texel_color[15:8]) * 17'(fog)) >> 8);
      blue  = 8'((17'(req_item.texel_color[7:0]) * 17'(fog)) >> 8);
   end

   // Assemble the classified item.
   always_comb begin
      item        = '0;
      item.action = req_item.action;
      item.skip   = (27'(ad) * SkipScale) < 27'({half, 4'b0000});
      item.sat    = num >= {ad, 14'b0};
      item.ad     = ad;
      item.num    = num;
      item.ray_x  = req_item.ray_dir_x;
      item.ray_y  = req_item.ray_dir_y;
      item.tw     = (req_item.tex_width == '0) ? 11'd1 :
                    (req_item.tex_width > SizeCap) ? SizeCap : req_item.tex_width;
      item.th     = (req_item.tex_height == '0) ? 11'd1 :
                    (req_item.tex_height > SizeCap) ? SizeCap : req_item.tex_height;
      item.fog    = fog;
      item.color  = {red, green, blue};
   end

endmodule

FILE: rtl/core/fctf_back.sv
// ----------------------------------------------------------------------------
// fctf_back
// Carries out a located item: distance divider, world point, texture scale,
// wrap onto the texture and fog. Shade and skipped items ride along.
// ----------------------------------------------------------------------------
module fctf_back
   import fctf_pkg::*;
(
   input  logic      clock,
   input  logic      reset,
   input  cfg_type   cfg,
   input  front_type head_item,
   input  logic      head_valid,
   output logic      head_pop,
   input  logic      out_full,
   output logic      out_push,
   output rsp_type   out_item
);

   work_type pipe_ff   [PipeLen];
   work_type work_in   [PipeLen];
   work_type work_next [PipeLen];
   logic     vld_ff    [PipeLen];
   logic     adv;
   work_type last;

   // The whole pipeline moves unless the last item cannot leave.
   assign adv      = !(vld_ff[PipeLen-1] && out_full);
   assign head_pop = adv && head_valid;
   assign out_push = vld_ff[PipeLen-1] && !out_full;

   // First stage starts the division from the queue head.
   always_comb begin
      work_in[0]       = '0;
      work_in[0].f     = head_item;
      work_in[0].rem   = head_item.num[30:14];
      work_in[0].xbits = {head_item.num[13:0], 12'b0};
   end

   for (genvar g = 1; g < PipeLen; g++) begin : g_link
      assign work_in[g] = pipe_ff[g-1];
   end

   // Stage logic, selected by position in the pipeline.
   always_comb begin
      work_type    w;
      work_type    nxt;
      logic [17:0] t;
      logic        qbit;
      logic [25:0] d;
      logic [63:0] mx, my;
      logic [11:0] tx, ty;
      for (int i = 0; i < PipeLen; i++) begin
         w    = work_in[i];
         nxt  = w;
         t    = '0;
         qbit = 1'b0;
         d    = '0;
         mx   = '0;
         my   = '0;
         tx   = '0;
         ty   = '0;
         if (i < StClamp) begin
            // One restoring division step of the row distance.
            t = {w.rem, w.xbits[25]};
            if (t >= {1'b0, w.f.ad}) begin
               nxt.rem = 17'(t - {1'b0, w.f.ad});
               qbit    = 1'b1;
            end else begin
               nxt.rem = t[16:0];
               qbit    = 1'b0;
            end
            nxt.quo   = {w.quo[24:0], qbit};
            nxt.xbits = {w.xbits[24:0], 1'b0};
         end else if (i == StClamp) begin
            // Clamp the distance to its legal range.
            if (w.f.sat || (w.quo > DistMax)) begin
               d = DistMax;
            end else if (w.quo < DistMin) begin
               d = DistMin;
            end else begin
               d = w.quo;
            end
            nxt.row_dist = d;
            nxt.dfog = (d > 26'(FogClampD)) ? FogClampD : d[23:0];
         end else if (i == StMul) begin
            // Ray times distance, and the fog reciprocal product.
            nxt.px    = w.f.ray_x * $signed({1'b0, w.row_dist});
            nxt.py    = w.f.ray_y * $signed({1'b0, w.row_dist});
            nxt.fprod = w.dfog * FogRecip;
         end else if (i == StSum) begin
            // Camera plus offset, and the fog factor of a located item.
            nxt.wx = (47'(cfg.cam_x) <<< 22) + 47'(w.px);
            nxt.wy = (47'(cfg.cam_y) <<< 22) + 47'(w.py);
            if (w.f.action == ActLocate) begin
               nxt.f.fog = FogFull - {1'b0, w.fprod[47:40]};
            end
         end else if (i == StPart) begin
            // Texture scale in two partial products per axis.
            nxt.hx = $signed(w.wx[46:24]) * $signed({1'b0, cfg.tex_scale});
            nxt.hy = $signed(w.wy[46:24]) * $signed({1'b0, cfg.tex_scale});
            nxt.lx = w.wx[23:0] * cfg.tex_scale;
            nxt.ly = w.wy[23:0] * cfg.tex_scale;
         end else if (i == StAdd) begin
            nxt.sx = (64'(w.hx) <<< 24) + $signed({24'b0, w.lx});
            nxt.sy = (64'(w.hy) <<< 24) + $signed({24'b0, w.ly});
         end else if (i == StAbs) begin
            // Integer part of the magnitude, truncated toward zero.
            mx       = w.sx[63] ? 64'(-w.sx) : 64'(w.sx);
            my       = w.sy[63] ? 64'(-w.sy) : 64'(w.sy);
            nxt.negx = w.sx[63];
            nxt.negy = w.sy[63];
            nxt.magx = mx[62:38];
            nxt.magy = my[62:38];
            nxt.remx = '0;
            nxt.remy = '0;
         end else begin
            // One remainder step against the texture size.
            tx = {w.remx, w.magx[24]};
            ty = {w.remy, w.magy[24]};
            nxt.remx = (tx >= {1'b0, w.f.tw}) ? 11'(tx - {1'b0, w.f.tw}) : tx[10:0];
            nxt.remy = (ty >= {1'b0, w.f.th}) ? 11'(ty - {1'b0, w.f.th}) : ty[10:0];
            nxt.magx = {w.magx[23:0], 1'b0};
            nxt.magy = {w.magy[23:0], 1'b0};
         end
         work_next[i] = nxt;
      end
   end

   // Valid bits of the stages.
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < PipeLen; i++) begin
            vld_ff[i] <= 1'b0;
         end
      end else if (adv) begin
         vld_ff[0] <= head_valid;
         for (int i = 1; i < PipeLen; i++) begin
            vld_ff[i] <= vld_ff[i-1];
         end
      end
   end

   // Stage payloads.
   always_ff @(posedge clock) begin
      if (adv) begin
         for (int i = 0; i < PipeLen; i++) begin
            pipe_ff[i] <= work_next[i];
         end
      end
   end

   // Final fix-up: a negative coordinate wraps to the nonnegative residue.
   always_comb begin
      last     = pipe_ff[PipeLen-1];
      out_item = '0;
      if (last.f.action == ActShade) begin
         out_item.fog_factor   = last.f.fog;
         out_item.shaded_color = last.f.color;
      end else if (last.f.skip) begin
         out_item.skipped = 1'b1;
      end else begin
         out_item.tex_x = (last.negx && (last.remx != '0)) ?
                          10'(last.f.tw - last.remx) : last.remx[9:0];
         out_item.tex_y = (last.negy && (last.remy != '0)) ?
                          10'(last.f.th - last.remy) : last.remy[9:0];
         out_item.fog_factor = last.f.fog;
      end
   end

endmodule

FILE: rtl/core/floor_ceiling_texel_fog.sv
// ----------------------------------------------------------------------------
// floor_ceiling_texel_fog
// Perspective floor and ceiling texel locator with distance fog.
// ----------------------------------------------------------------------------
// The block takes one item per clock unless a queue is full and returns one
// result per item in order, through the front queue, 57 pipeline stages and
// the result queue. The length is set by the row distance divider (26 stages,
// one quotient bit each) and the texture wrap (25 stages, one remainder bit
// each), which run fully pipelined. The user must write configuration over
// the APB port only while no item is in flight; the block does not check it.
module floor_ceiling_texel_fog
   import fctf_pkg::*;
#(
   parameter int unsigned MAX_TEX_SIZE    = 1024,
   parameter int unsigned MAX_SCREEN_ROWS = 2048
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_push,
   input  req_type     req_item,
   output logic        req_full,
   input  logic        rsp_pop,
   output rsp_type     rsp_item,
   output logic        rsp_empty,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [4:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);

   cfg_type   cfg_ff, cfg_in;
   front_type front_item, head_item;
   logic      mid_empty, head_pop;
   logic      out_full, out_push;
   rsp_type   out_item;
   logic      cfg_write;
   logic [2:0] reg_idx;

   assign csr_pready = 1'b1;
   assign cfg_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign reg_idx    = csr_paddr[4:2];

   // Register writes.
   always_comb begin
      cfg_in = cfg_ff;
      if (cfg_write) begin
         case (reg_idx)
            RegHorizonRow: cfg_in.horizon_row   = csr_pwdata[15:0];
            RegHalfScreen: cfg_in.half_screen_h = csr_pwdata[10:0];
            RegCamX:       cfg_in.cam_x         = csr_pwdata[23:0];
            RegCamY:       cfg_in.cam_y         = csr_pwdata[23:0];
            RegTexScale:   cfg_in.tex_scale     = csr_pwdata[15:0];
            default:       cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.horizon_row   <= '0;
         cfg_ff.half_screen_h <= HalfScreenReset;
         cfg_ff.cam_x         <= '0;
         cfg_ff.cam_y         <= '0;
         cfg_ff.tex_scale     <= TexScaleReset;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // Register reads.
   always_comb begin
      case (reg_idx)
         RegHorizonRow: csr_prdata = {16'b0, cfg_ff.horizon_row};
         RegHalfScreen: csr_prdata = {21'b0, cfg_ff.half_screen_h};
         RegCamX:       csr_prdata = {8'b0, cfg_ff.cam_x};
         RegCamY:       csr_prdata = {8'b0, cfg_ff.cam_y};
         RegTexScale:   csr_prdata = {16'b0, cfg_ff.tex_scale};
         default:       csr_prdata = '0;
      endcase
   end

   // Front: classify the incoming item.
   fctf_front #(
      .MAX_TEX_SIZE    (MAX_TEX_SIZE),
      .MAX_SCREEN_ROWS (MAX_SCREEN_ROWS)
   ) u_front (
      .req_item (req_item),
      .cfg      (cfg_ff),
      .item     (front_item)
   );

   // Queue between front and back.
   fctf_fifo #(
      .item_type (front_type),
      .DEPTH     (4)
   ) u_mid_queue (
      .clock (clock),
      .reset (reset),
      .push  (req_push),
      .wdata (front_item),
      .full  (req_full),
      .pop   (head_pop),
      .rdata (head_item),
      .empty (mid_empty)
   );

   // Back: the arithmetic pipeline.
   fctf_back u_back (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg_ff),
      .head_item  (head_item),
      .head_valid (!mid_empty),
      .head_pop   (head_pop),
      .out_full   (out_full),
      .out_push   (out_push),
      .out_item   (out_item)
   );

   // Result queue.
   fctf_fifo #(
      .item_type (rsp_type),
      .DEPTH     (4)
   ) u_out_queue (
      .clock (clock),
      .reset (reset),
      .push  (out_push),
      .wdata (out_item),
      .full  (out_full),
      .pop   (rsp_pop),
      .rdata (rsp_item),
      .empty (rsp_empty)
   );

endmodule

FILE: rtl/core/fctf_checker.sv
// ----------------------------------------------------------------------------
// fctf_checker
// Port-level checks on the results of the floor and ceiling texel block.
// ----------------------------------------------------------------------------
`include "floor_ceiling_texel_fog_assert.svh"

module fctf_checker
   import fctf_pkg::*;
(
   input logic    clock,
   input logic    reset,
   input logic    req_full,
   input logic    rsp_pop,
   input rsp_type rsp_item,
   input logic    rsp_empty
);

   // A skipped row carries no texel, fog or colour.
   `FCTF_ASSERT_NOW(a_skip_clean, clock, reset, !rsp_empty && rsp_item.skipped, rsp_item.tex_x == 10'd0 && rsp_item.tex_y == 10'd0 && rsp_item.fog_factor == 9'd0 && rsp_item.shaded_color == 24'd0, "skipped item carries data")

   // Every drawn item has a fog factor between a quarter and one.
   `FCTF_ASSERT_NOW(a_fog_range, clock, reset, !rsp_empty && !rsp_item.skipped, rsp_item.fog_factor >= 9'd64 && rsp_item.fog_factor <= 9'd256, "fog factor out of range")

   // A shaded colour never comes with texel coordinates.
   `FCTF_ASSERT_NOW(a_shade_only, clock, reset, !rsp_empty && rsp_item.shaded_color != 24'd0, rsp_item.tex_x == 10'd0 && rsp_item.tex_y == 10'd0 && !rsp_item.skipped, "shade item has texel data")

   // A waiting item stays until it is taken.
   `FCTF_ASSERT_NEXT(a_hold, clock, reset, !rsp_empty && !rsp_pop, !rsp_empty && $stable(rsp_item), "waiting item changed")

   // After reset the result queue is empty and the request queue is not full.
   `FCTF_ASSERT_NOW(a_reset_empty, clock, reset, $past(reset), rsp_empty && !req_full, "queues not empty after reset")

endmodule

bind floor_ceiling_texel_fog fctf_checker u_checker (
   .clock     (clock),
   .reset     (reset),
   .req_full  (req_full),
   .rsp_pop   (rsp_pop),
   .rsp_item  (rsp_item),
   .rsp_empty (rsp_empty)
);
